@@ rtl/core/ble_pkg.sv @@
// shared types and constants for the battery level estimator
package ble_pkg;

  localparam int unsigned MV_W       = 16;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned GAIN_FRAC  = 12;
  localparam int unsigned THR_COUNT  = 4;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // queue between front and back, and the result queue (powers of two)
  localparam int unsigned MID_DEPTH  = 4;
  localparam int unsigned MID_CNT_W  = 3;
  localparam int unsigned OUT_DEPTH  = 8;
  localparam int unsigned OUT_CNT_W  = 4;

  // level step = max_level / steps, done as multiply by reciprocal and shift
  localparam int unsigned STEP_SHIFT = 10;
  localparam int unsigned STEP_RCP_W = 11;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DIVIDER_GAIN = 3'd0,
    REG_THRESHOLD_0  = 3'd1,
    REG_THRESHOLD_1  = 3'd2,
    REG_THRESHOLD_2  = 3'd3,
    REG_THRESHOLD_3  = 3'd4,
    REG_MAX_LEVEL    = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [GAIN_W-1:0]                divider_gain;
    logic [THR_COUNT-1:0][MV_W-1:0]   thresholds;
    logic [LEVEL_W-1:0]               max_level;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [MV_W-1:0]    mean;
  } result_t;

endpackage

@@ rtl/core/ble_ram.sv @@
// generic single write port ram with registered read
module ble_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/ble_fifo.sv @@
// small register queue, depth a power of two
module ble_fifo #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  logic [WIDTH-1:0]                 data_in,
  input  logic                             pop,
  output logic [WIDTH-1:0]                 data_out,
  output logic                             full,
  output logic                             empty,
  output logic [$clog2(DEPTH+1)-1:0]       count
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign data_out = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ rtl/core/ble_front.sv @@
// front end: input register and divider gain scaling
module ble_front (
  input  logic                        clk,
  input  logic                        rst,
  input  ble_pkg::cfg_t               cfg,
  input  logic                        push,
  output logic                        full,
  input  logic [ble_pkg::MV_W-1:0]    pin_millivolts,
  input  logic                        sample_ok,
  output logic                        q_push,
  output logic [ble_pkg::MV_W-1:0]    q_data,
  input  logic                        q_full
);
  import ble_pkg::*;

  localparam int unsigned PROD_W = MV_W + GAIN_W;
  localparam int unsigned SHR_W  = PROD_W - GAIN_FRAC;

  logic              in_valid;
  logic [MV_W-1:0]   in_pin;
  logic              in_ok;
  logic [PROD_W-1:0] prod;
  logic [SHR_W-1:0]  scaled;

  assign full   = in_valid && q_full;
  assign q_push = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!full) begin
      in_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      in_pin <= pin_millivolts;
      in_ok  <= sample_ok;
    end
  end

  // q4.12 gain, truncate, saturate at full scale; a failed sample reads as zero
  always_comb begin
    prod   = PROD_W'(in_pin) * PROD_W'(cfg.divider_gain);
    scaled = prod[PROD_W-1:GAIN_FRAC];
    if (!in_ok) begin
      q_data = '0;
    end else if (|scaled[SHR_W-1:MV_W]) begin
      q_data = '1;
    end else begin
      q_data = scaled[MV_W-1:0];
    end
  end

endmodule

@@ rtl/core/ble_back.sv @@
// back end: ring update, running sum, mean and threshold ladder
module ble_back #(
  parameter int unsigned AVERAGE_DEPTH = 8,
  parameter int unsigned LEVEL_STEPS   = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ble_pkg::cfg_t                  cfg,
  input  logic                           q_empty,
  input  logic [ble_pkg::MV_W-1:0]       q_data,
  output logic                           q_pop,
  input  logic [ble_pkg::OUT_CNT_W-1:0]  out_count,
  output logic                           res_push,
  output ble_pkg::result_t               res_data
);
  import ble_pkg::*;

  localparam int unsigned LOG_D  = $clog2(AVERAGE_DEPTH);
  localparam int unsigned PW     = (AVERAGE_DEPTH > 1) ? LOG_D : 1;
  localparam int unsigned SW     = MV_W + LOG_D;
  localparam int unsigned K      = SW + LOG_D;
  localparam longint unsigned RCP_L =
    ((longint'(1) << K) + longint'(AVERAGE_DEPTH) - 1) / longint'(AVERAGE_DEPTH);
  localparam logic [K:0] RCP     = RCP_L[K:0];
  localparam int unsigned MW     = SW + K + 1;
  localparam logic [STEP_RCP_W-1:0] STEP_RCP =
    STEP_RCP_W'(((1 << STEP_SHIFT) + LEVEL_STEPS - 1) / LEVEL_STEPS);
  localparam int unsigned CRW    = OUT_CNT_W + 1;
  localparam int unsigned STEP_PW = LEVEL_W + STEP_RCP_W;

  logic [PW-1:0]            pos;
  logic [AVERAGE_DEPTH-1:0] ring_valid;
  logic [SW-1:0]            sum;
  logic [SW-1:0]            sum_next;
  logic [MV_W-1:0]          ram_rdata;
  logic [MV_W-1:0]          old_sample;

  // stage 1: ram data back, sum update, ring write
  logic            s1_valid;
  logic [PW-1:0]   s1_addr;
  logic [MV_W-1:0] s1_sample;
  logic            s1_old_valid;
  logic            s1_byp;
  logic [MV_W-1:0] s1_byp_data;
  // stage 2: reciprocal multiply
  logic            s2_valid;
  logic [SW-1:0]   s2_sum;
  logic [MW-1:0]   s2_prod;
  // stage 3: ladder
  logic            s3_valid;
  logic [MV_W-1:0] s3_mean;

  logic [LEVEL_W-1:0] step;
  logic [STEP_PW-1:0] step_prod;
  logic [2:0]         ladder_count;
  logic               ladder_stop;
  logic [1:0]         inflight;

  assign inflight = 2'(s1_valid) + 2'(s2_valid) + 2'(s3_valid);
  assign q_pop    = !q_empty &&
                    ((CRW'(out_count) + CRW'(inflight)) < CRW'(OUT_DEPTH));

  ble_ram #(
    .WIDTH (MV_W),
    .DEPTH (AVERAGE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_addr),
    .wdata (s1_sample),
    .raddr (pos),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      ring_valid <= '0;
      sum        <= '0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
    end else begin
      s1_valid <= q_pop;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      if (q_pop) begin
        if (pos == PW'(AVERAGE_DEPTH - 1)) begin
          pos <= '0;
        end else begin
          pos <= pos + PW'(1);
        end
      end
      if (s1_valid) begin
        ring_valid[s1_addr] <= 1'b1;
        sum                 <= sum_next;
      end
    end
  end

  // a same-address write still in stage 1 at the ring read is forwarded
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_addr      <= pos;
      s1_sample    <= q_data;
      s1_old_valid <= ring_valid[pos];
      s1_byp       <= s1_valid && (s1_addr == pos);
      s1_byp_data  <= s1_sample;
    end
    s2_sum  <= sum_next;
    s3_mean <= s2_prod[K +: MV_W];
    step    <= step_prod[STEP_SHIFT +: LEVEL_W];
  end

  always_comb begin
    if (s1_byp) begin
      old_sample = s1_byp_data;
    end else if (s1_old_valid) begin
      old_sample = ram_rdata;
    end else begin
      old_sample = '0;
    end
    sum_next  = sum - SW'(old_sample) + SW'(s1_sample);
    s2_prod   = MW'(s2_sum) * MW'(RCP);
    step_prod = STEP_PW'(cfg.max_level) * STEP_PW'(STEP_RCP);
  end

  always_comb begin
    ladder_count = '0;
    ladder_stop  = 1'b0;
    for (int i = 0; i < THR_COUNT; i++) begin
      if (i < LEVEL_STEPS && !ladder_stop) begin
        if (s3_mean < cfg.thresholds[i]) begin
          ladder_stop = 1'b1;
        end else begin
          ladder_count = ladder_count + 3'd1;
        end
      end
    end
  end

  assign res_push       = s3_valid;
  assign res_data.mean  = s3_mean;
  assign res_data.level = LEVEL_W'(step * LEVEL_W'(ladder_count));

endmodule

@@ rtl/core/battery_level_estimator_core.sv @@
// top level of the battery level estimator: config registers, front, queues, back
//
//   channel   direction  handshake                 words
//   input     in         push / full               pin_millivolts, sample_ok
//   result    out        empty / pop               battery_level, average_millivolts
//   config    in         write_enable (no wait)    write_index, write_data
//
// one word per cycle sustained if pop keeps up; empty goes low after the word passes
// the input register, mid queue, ram read, sum update, reciprocal multiply and ladder
// the ring ram read in the back end sets the pace: one ring access per cycle
// rst is synchronous; the ring reads as zero after reset through per-entry valid bits
// back end issues only with room in the result queue, so a stalled pop backs up
// into the mid queue and then raises full
module battery_level_estimator_core #(
  parameter int unsigned AVERAGE_DEPTH = 8,
  parameter int unsigned LEVEL_STEPS   = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  // input word
  input  logic                             push,
  output logic                             full,
  input  logic [ble_pkg::MV_W-1:0]         pin_millivolts,
  input  logic                             sample_ok,
  // result word
  output logic                             empty,
  input  logic                             pop,
  output logic [ble_pkg::LEVEL_W-1:0]      battery_level,
  output logic [ble_pkg::MV_W-1:0]         average_millivolts,
  // config write port
  input  logic                             write_enable,
  input  logic [ble_pkg::REG_IDX_W-1:0]    write_index,
  input  logic [ble_pkg::CFG_DATA_W-1:0]   write_data
);
  import ble_pkg::*;

  cfg_t                 cfg;

  // front to mid queue
  logic                 mid_push;
  logic [MV_W-1:0]      mid_in;
  logic                 mid_full;
  // mid queue to back
  logic                 mid_pop;
  logic [MV_W-1:0]      mid_out;
  logic                 mid_empty;
  logic [MID_CNT_W-1:0] mid_count;
  // back to result queue
  logic                 res_push;
  result_t              res_data;
  result_t              res_head;
  logic                 out_full;
  logic [OUT_CNT_W-1:0] out_count;

  // config registers, out-of-range indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.divider_gain  <= 16'd4096;
      cfg.thresholds[0] <= 16'd3300;
      cfg.thresholds[1] <= 16'd3600;
      cfg.thresholds[2] <= 16'd3800;
      cfg.thresholds[3] <= 16'd4000;
      cfg.max_level     <= 8'd100;
    end else if (write_enable) begin
      case (reg_index_t'(write_index))
        REG_DIVIDER_GAIN: cfg.divider_gain  <= write_data;
        REG_THRESHOLD_0:  cfg.thresholds[0] <= write_data;
        REG_THRESHOLD_1:  cfg.thresholds[1] <= write_data;
        REG_THRESHOLD_2:  cfg.thresholds[2] <= write_data;
        REG_THRESHOLD_3:  cfg.thresholds[3] <= write_data;
        REG_MAX_LEVEL:    cfg.max_level     <= write_data[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: takes the word and scales it to battery millivolts
  ble_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .push           (push),
    .full           (full),
    .pin_millivolts (pin_millivolts),
    .sample_ok      (sample_ok),
    .q_push         (mid_push),
    .q_data         (mid_in),
    .q_full         (mid_full)
  );

  // scaled samples waiting for the back end
  ble_fifo #(
    .WIDTH (MV_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk      (clk),
    .rst      (rst),
    .push     (mid_push),
    .data_in  (mid_in),
    .pop      (mid_pop),
    .data_out (mid_out),
    .full     (mid_full),
    .empty    (mid_empty),
    .count    (mid_count)
  );

  // back: ring, running sum, mean, level ladder
  ble_back #(
    .AVERAGE_DEPTH (AVERAGE_DEPTH),
    .LEVEL_STEPS   (LEVEL_STEPS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (mid_empty),
    .q_data    (mid_out),
    .q_pop     (mid_pop),
    .out_count (out_count),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  // finished words waiting for pop
  ble_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .data_in  (res_data),
    .pop      (pop),
    .data_out (res_head),
    .full     (out_full),
    .empty    (empty),
    .count    (out_count)
  );

  assign battery_level      = res_head.level;
  assign average_millivolts = res_head.mean;

  // back end credit keeps the result queue from overflowing
  assert property (@(posedge clk) disable iff (rst) res_push |-> !out_full)
    else $error("result word pushed into a full result queue");

  // front never hands a sample to a full mid queue
  assert property (@(posedge clk) disable iff (rst) mid_push |-> !mid_full)
    else $error("sample pushed into a full mid queue");

  // every issued sample comes out of the back end after stages 1, 2 and 3
  assert property (@(posedge clk) disable iff (rst) mid_pop |-> ##3 res_push)
    else $error("issued sample did not produce a result word");

  // nothing is waiting right after reset
  assert property (@(posedge clk) rst |=> (empty && mid_count == '0))
    else $error("queues not empty after reset");

endmodule

@@ dv/battery_level_estimator_core_tb.sv @@
// self-checking testbench for the battery level estimator core
module battery_level_estimator_core_tb;
  import ble_pkg::*;

  localparam int unsigned RING_DEPTH   = 8;
  localparam int unsigned LADDER_STEPS = 4;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned RANDOM_PHASES = 8;

  // indexes past the last register, writes there must be dropped
  localparam logic [REG_IDX_W-1:0] SPARE_INDEX_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] SPARE_INDEX_HI = 3'd7;

  typedef enum int unsigned {
    MIX_NEAR,
    MIX_GRID,
    MIX_WIDE
  } mix_t;

  // one input word waiting to be sent; drain holds it back until all readings are in
  typedef struct packed {
    logic [MV_W-1:0] pin;
    logic            ok;
    logic            drain;
  } sample_t;

  // predicted reading, stamped with the cycle of the accepting edge
  typedef struct packed {
    logic [31:0] stamp;
    result_t     reading;
  } awaited_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  logic [MV_W-1:0]       pin_millivolts = '0;
  logic                  sample_ok = 1'b0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [LEVEL_W-1:0]    battery_level;
  logic [MV_W-1:0]       average_millivolts;
  logic                  write_enable = 1'b0;
  logic [REG_IDX_W-1:0]  write_index = '0;
  logic [CFG_DATA_W-1:0] write_data = '0;

  battery_level_estimator_core #(
    .AVERAGE_DEPTH(RING_DEPTH),
    .LEVEL_STEPS  (LADDER_STEPS)
  ) uut (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .pin_millivolts    (pin_millivolts),
    .sample_ok         (sample_ok),
    .empty             (empty),
    .pop               (pop),
    .battery_level     (battery_level),
    .average_millivolts(average_millivolts),
    .write_enable      (write_enable),
    .write_index       (write_index),
    .write_data        (write_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the config registers and of the averaging ring
  logic [GAIN_W-1:0]  gain_q12;
  logic [MV_W-1:0]    ladder_mv [THR_COUNT];
  logic [LEVEL_W-1:0] full_scale;
  logic [MV_W-1:0]    hist_mv [RING_DEPTH];
  int unsigned        hist_slot;
  int unsigned        hist_total;

  sample_t     sample_queue [$];
  awaited_t    awaited_readings [$];
  int unsigned errors = 0;
  logic [31:0] cycles = '0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // mostly short gaps, a few long ones
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // scale, push into the ring, average, climb the threshold ladder
  function automatic result_t predict_reading(input logic [MV_W-1:0] pin, input logic ok);
    logic [31:0] product;
    logic [31:0] scaled;
    int unsigned avg;
    int unsigned passed;
    logic        stopped;
    result_t     r;
    scaled = '0;
    if (ok) begin
      product = {16'b0, pin} * {16'b0, gain_q12};
      scaled = product >> GAIN_FRAC;
      if (scaled > 32'hFFFF) scaled = 32'hFFFF;
    end
    hist_total = hist_total - hist_mv[hist_slot] + scaled;
    hist_mv[hist_slot] = scaled[MV_W-1:0];
    hist_slot = (hist_slot == RING_DEPTH - 1) ? 0 : hist_slot + 1;
    avg = hist_total / RING_DEPTH;
    passed = 0;
    stopped = 1'b0;
    for (int i = 0; i < LADDER_STEPS; i++) begin
      if (!stopped) begin
        if (avg < ladder_mv[i]) stopped = 1'b1;
        else passed++;
      end
    end
    r.level = LEVEL_W'((full_scale / LADDER_STEPS) * passed);
    r.mean  = avg[MV_W-1:0];
    return r;
  endfunction

  // driver: offers queued words, predicts each one on acceptance
  logic        offer;
  sample_t     next_sample;
  int unsigned send_gap = 0;
  int unsigned send_steady = 0;

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      offer = push;
      if (push && !full) begin
        awaited_readings.push_back({cycles, predict_reading(pin_millivolts, sample_ok)});
        offer = 1'b0;
        if (send_steady > 0) begin
          send_steady--;
          send_gap = 0;
        end else begin
          send_gap = draw_gap();
          if ($urandom_range(0, 39) == 0) send_steady = $urandom_range(20, 80);
        end
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (sample_queue.size() > 0 &&
                     !(sample_queue[0].drain && awaited_readings.size() > 0)) begin
          next_sample = sample_queue.pop_front();
          pin_millivolts <= next_sample.pin;
          sample_ok <= next_sample.ok;
          offer = 1'b1;
        end
      end
      push <= offer;
    end
  end

  // monitor: pops with random stalls, checks against the oldest reading
  logic        want_pop;
  awaited_t    head;
  int unsigned recv_gap = 0;
  int unsigned recv_steady = 0;

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      want_pop = pop;
      if (pop && !empty) begin
        // a reading predicted at this very edge cannot be the one on the ports
        if (awaited_readings.size() == 0 || awaited_readings[0].stamp == cycles) begin
          report_mismatch($sformatf("word with no reading awaited: level %0d mean %0d",
                                    battery_level, average_millivolts));
        end else begin
          head = awaited_readings.pop_front();
          if (battery_level !== head.reading.level)
            report_mismatch($sformatf("battery_level got %0d expected %0d",
                                      battery_level, head.reading.level));
          if (average_millivolts !== head.reading.mean)
            report_mismatch($sformatf("average_millivolts got %0d expected %0d",
                                      average_millivolts, head.reading.mean));
        end
        if (recv_steady > 0) begin
          recv_steady--;
          recv_gap = 0;
        end else begin
          recv_gap = draw_gap();
          if ($urandom_range(0, 39) == 0) recv_steady = $urandom_range(20, 80);
        end
        want_pop = (recv_gap == 0);
      end else if (!pop) begin
        if (recv_gap > 0) recv_gap--;
        want_pop = (recv_gap == 0);
      end
      pop <= want_pop;
    end
  end

  task automatic add_sample(input logic [MV_W-1:0] pin, input logic ok, input logic drain);
    sample_queue.push_back({pin, ok, drain});
  endtask

  // register write, shadow updated at the same time (block is idle here)
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= data;
    case (idx)
      REG_DIVIDER_GAIN: gain_q12 = data;
      REG_THRESHOLD_0:  ladder_mv[0] = data;
      REG_THRESHOLD_1:  ladder_mv[1] = data;
      REG_THRESHOLD_2:  ladder_mv[2] = data;
      REG_THRESHOLD_3:  ladder_mv[3] = data;
      REG_MAX_LEVEL:    full_scale = data[LEVEL_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  // wait for every word to go out and every reading to come back, plus pipeline drain
  task automatic settle();
    do @(negedge clk);
    while (sample_queue.size() != 0 || push || awaited_readings.size() != 0);
    repeat (12) @(negedge clk);
  endtask

  initial begin
    mix_t        mix;
    int unsigned n_items;
    int unsigned drain_at;
    int unsigned t;
    logic [7:0]  lvl;

    gain_q12 = 16'd4096;
    ladder_mv[0] = 16'd3300;
    ladder_mv[1] = 16'd3600;
    ladder_mv[2] = 16'd3800;
    ladder_mv[3] = 16'd4000;
    full_scale = 8'd100;
    for (int i = 0; i < RING_DEPTH; i++) hist_mv[i] = '0;
    hist_slot = 0;
    hist_total = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: field extremes, failed measurement, fill ring up to the top threshold
    add_sample(16'h0000, 1'b1, 1'b0);
    add_sample(16'hFFFF, 1'b1, 1'b0);
    add_sample(16'hFFFF, 1'b0, 1'b0);
    add_sample(16'h5555, 1'b1, 1'b0);
    add_sample(16'hAAAA, 1'b1, 1'b0);
    repeat (8) add_sample(16'd4000, 1'b1, 1'b0);
    settle();

    // max gain: saturation just past the unity point, truncation of tiny inputs
    write_reg(REG_DIVIDER_GAIN, 16'hFFFF);
    write_reg(REG_THRESHOLD_0, 16'h0000);
    write_reg(REG_THRESHOLD_1, 16'h0000);
    write_reg(REG_THRESHOLD_2, 16'hFFFF);
    write_reg(REG_THRESHOLD_3, 16'h0000);
    write_reg(REG_MAX_LEVEL, 16'h00FF);
    @(negedge clk);
    add_sample(16'd4096, 1'b1, 1'b0);
    add_sample(16'd4097, 1'b1, 1'b0);
    add_sample(16'd1, 1'b1, 1'b0);
    add_sample(16'hFFFF, 1'b1, 1'b0);
    settle();

    // zero gain, zero full scale, writes to spare indexes dropped
    write_reg(REG_DIVIDER_GAIN, 16'h0000);
    write_reg(REG_MAX_LEVEL, 16'hFF00);
    write_reg(SPARE_INDEX_LO, 16'h1234);
    write_reg(SPARE_INDEX_HI, 16'hFFFF);
    @(negedge clk);
    add_sample(16'hFFFF, 1'b1, 1'b0);
    add_sample(16'h8001, 1'b0, 1'b0);
    settle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      mix = mix_t'(phase % 3);
      case (mix)
        MIX_NEAR: begin
          write_reg(REG_DIVIDER_GAIN, 16'($urandom_range(3500, 4700)));
          if (phase % 2 == 0) begin
            // ascending ladder
            t = $urandom_range(2000, 3200);
            for (int i = 0; i < THR_COUNT; i++) begin
              write_reg(reg_index_t'(REG_THRESHOLD_0 + i), 16'(t));
              t = t + $urandom_range(0, 900);
            end
          end else begin
            // ladder out of order, counting stops early
            for (int i = 0; i < THR_COUNT; i++)
              write_reg(reg_index_t'(REG_THRESHOLD_0 + i), 16'($urandom_range(2000, 6000)));
          end
        end
        MIX_GRID: begin
          // means land on multiples of 100, so ties with thresholds are common
          write_reg(REG_DIVIDER_GAIN, 16'd4096);
          for (int i = 0; i < THR_COUNT; i++)
            write_reg(reg_index_t'(REG_THRESHOLD_0 + i), 16'(100 * $urandom_range(0, 64)));
        end
        default: begin
          write_reg(REG_DIVIDER_GAIN, 16'($urandom));
          for (int i = 0; i < THR_COUNT; i++)
            write_reg(reg_index_t'(REG_THRESHOLD_0 + i), 16'($urandom));
        end
      endcase
      if (phase == 1) lvl = 8'd0;
      else if (phase == 2) lvl = 8'd255;
      else lvl = 8'($urandom_range(0, 255));
      write_reg(REG_MAX_LEVEL, {8'($urandom_range(0, 255)), lvl});
      write_reg($urandom_range(0, 1) ? SPARE_INDEX_HI : SPARE_INDEX_LO, 16'($urandom));
      @(negedge clk);

      n_items = 110 + $urandom_range(0, 18);
      drain_at = $urandom_range(10, n_items - 10);
      for (int k = 0; k < n_items; k++) begin
        case (mix)
          MIX_NEAR: add_sample(16'($urandom_range(1500, 6500)),
                               $urandom_range(0, 9) != 0, k == drain_at);
          MIX_GRID: add_sample(16'(800 * $urandom_range(0, 8)),
                               $urandom_range(0, 9) != 0, k == drain_at);
          default:  add_sample(16'($urandom), 1'($urandom), k == drain_at);
        endcase
      end
      settle();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/ble_pkg.sv
rtl/core/ble_ram.sv
rtl/core/ble_fifo.sv
rtl/core/ble_front.sv
rtl/core/ble_back.sv
rtl/core/battery_level_estimator_core.sv
dv/battery_level_estimator_core_tb.sv
